// ----- design/toh_pkg.sv -----
`default_nettype none

package toh_pkg;

	// Default sample width
	localparam int SAMPLE_WIDTH_DEF = 16;

	// Coefficient register port
	localparam int COEF_W = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_TIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOOSE = 2'd2;

	localparam logic [COEF_W-1:0] TIGHT_RST = 8'd192;
	localparam logic [COEF_W-1:0] BASE_RST  = 8'd128;
	localparam logic [COEF_W-1:0] LOOSE_RST = 8'd64;

	// Orientation codes
	localparam int ORI_W = 3;
	localparam logic [ORI_W-1:0] ORI_NONE = 3'd0;
	localparam logic [ORI_W-1:0] ORI_ZP   = 3'd1;
	localparam logic [ORI_W-1:0] ORI_ZN   = 3'd2;
	localparam logic [ORI_W-1:0] ORI_XP   = 3'd3;
	localparam logic [ORI_W-1:0] ORI_XN   = 3'd4;
	localparam logic [ORI_W-1:0] ORI_YP   = 3'd5;
	localparam logic [ORI_W-1:0] ORI_YN   = 3'd6;

	// Datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_SQX,
		OP_SQY,
		OP_SQZ,
		OP_SUM,
		OP_MULZ,
		OP_MULX,
		OP_DECIDE,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		logic load;
		op_t  op;
	} dp_cmd_t;

endpackage

`default_nettype wire

// ----- design/toh_ctrl.sv -----
`default_nettype none

module toh_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             kind,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output toh_pkg::dp_cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQX  = 3'd1;
	localparam logic [2:0] ST_SQY  = 3'd2;
	localparam logic [2:0] ST_SQZ  = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;
	localparam logic [2:0] ST_MZ   = 3'd5;
	localparam logic [2:0] ST_MX   = 3'd6;
	localparam logic [2:0] ST_DEC  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       clr_q;
	logic       out_valid_q;
	logic       accept;
	logic       fire;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	// Result slot is free when empty or being drained this cycle
	assign fire      = (state_q == ST_DEC) && (!out_valid_q || out_ready);

	// Sequence one item through the shared multiplier
	always_comb begin
		state_nx = state_q;
		cmd.load = 1'b0;
		cmd.op   = toh_pkg::OP_NOP;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_nx = kind ? ST_DEC : ST_SQX;
				end
			end
			ST_SQX: begin
				cmd.op   = toh_pkg::OP_SQX;
				state_nx = ST_SQY;
			end
			ST_SQY: begin
				cmd.op   = toh_pkg::OP_SQY;
				state_nx = ST_SQZ;
			end
			ST_SQZ: begin
				cmd.op   = toh_pkg::OP_SQZ;
				state_nx = ST_SUM;
			end
			ST_SUM: begin
				cmd.op   = toh_pkg::OP_SUM;
				state_nx = ST_MZ;
			end
			ST_MZ: begin
				cmd.op   = toh_pkg::OP_MULZ;
				state_nx = ST_MX;
			end
			ST_MX: begin
				cmd.op   = toh_pkg::OP_MULX;
				state_nx = ST_DEC;
			end
			ST_DEC: begin
				if (fire) begin
					cmd.op   = clr_q ? toh_pkg::OP_CLEAR : toh_pkg::OP_DECIDE;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// State, clear flag and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clr_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				clr_q <= kind;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/toh_datapath.sv -----
`default_nettype none

module toh_datapath #(
	parameter int SAMPLE_WIDTH = toh_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire toh_pkg::dp_cmd_t                    cmd,
	input  wire logic signed [SAMPLE_WIDTH-1:0]      accel_x,
	input  wire logic signed [SAMPLE_WIDTH-1:0]      accel_y,
	input  wire logic signed [SAMPLE_WIDTH-1:0]      accel_z,
	input  wire logic                                cfg_we,
	input  wire logic [toh_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [toh_pkg::COEF_W-1:0]          cfg_data,
	output logic [toh_pkg::ORI_W-1:0]                orientation
);

	localparam int SQW = 2 * SAMPLE_WIDTH;
	localparam int PW  = SQW + toh_pkg::COEF_W;

	logic [toh_pkg::COEF_W-1:0] tight_q, base_q, loose_q;
	logic [toh_pkg::ORI_W-1:0]  cur_q;

	logic [SAMPLE_WIDTH-1:0] mx_q, my_q, mz_q;
	logic                    px_q, py_q, pz_q;
	logic [SQW-1:0]          xx_q, yy_q, zz_q, sxy_q;
	logic [PW-1:0]           prod_q;
	logic                    zwin_q;

	logic [SAMPLE_WIDTH-1:0] sq_op;
	logic [SQW-1:0]          sq;
	logic [SQW-1:0]          sum3;
	logic [toh_pkg::COEF_W-1:0] cz, cx;
	logic [PW-1:0]           zz_sh, xx_sh;
	logic                    xwin;
	logic [toh_pkg::ORI_W-1:0] ori_nx;

	// Magnitude of a two's complement sample
	function automatic logic [SAMPLE_WIDTH-1:0] mag(input logic [SAMPLE_WIDTH-1:0] v);
		return v[SAMPLE_WIDTH-1] ? (~v + SAMPLE_WIDTH'(1)) : v;
	endfunction

	// Square one magnitude per cycle
	always_comb begin
		case (cmd.op)
			toh_pkg::OP_SQY: sq_op = my_q;
			toh_pkg::OP_SQZ: sq_op = mz_q;
			default:         sq_op = mx_q;
		endcase
	end
	assign sq   = SQW'(sq_op) * SQW'(sq_op);
	assign sum3 = sxy_q + zz_q;

	// Pick limits from the last orientation
	always_comb begin
		case (cur_q) inside
			toh_pkg::ORI_NONE: begin
				cz = base_q;
				cx = base_q;
			end
			toh_pkg::ORI_ZP, toh_pkg::ORI_ZN: begin
				cz = loose_q;
				cx = base_q;
			end
			toh_pkg::ORI_YP, toh_pkg::ORI_YN: begin
				cz = tight_q;
				cx = tight_q;
			end
			default: begin
				cz = tight_q;
				cx = loose_q;
			end
		endcase
	end

	assign zz_sh = {zz_q, toh_pkg::COEF_W'(0)};
	assign xx_sh = {xx_q, toh_pkg::COEF_W'(0)};
	assign xwin  = xx_sh > prod_q;

	// Resolve the winning axis and its sign
	always_comb begin
		if (zwin_q) begin
			ori_nx = pz_q ? toh_pkg::ORI_ZP : toh_pkg::ORI_ZN;
		end else if (xwin) begin
			ori_nx = px_q ? toh_pkg::ORI_XP : toh_pkg::ORI_XN;
		end else begin
			ori_nx = py_q ? toh_pkg::ORI_YP : toh_pkg::ORI_YN;
		end
	end

	// Coefficient registers and orientation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tight_q <= toh_pkg::TIGHT_RST;
			base_q  <= toh_pkg::BASE_RST;
			loose_q <= toh_pkg::LOOSE_RST;
			cur_q   <= toh_pkg::ORI_NONE;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					toh_pkg::REG_TIGHT: tight_q <= cfg_data;
					toh_pkg::REG_BASE:  base_q  <= cfg_data;
					toh_pkg::REG_LOOSE: loose_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.op == toh_pkg::OP_DECIDE) begin
				cur_q <= ori_nx;
			end else if (cmd.op == toh_pkg::OP_CLEAR) begin
				cur_q <= toh_pkg::ORI_NONE;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mx_q <= mag(accel_x);
			my_q <= mag(accel_y);
			mz_q <= mag(accel_z);
			px_q <= !accel_x[SAMPLE_WIDTH-1] && (accel_x != '0);
			py_q <= !accel_y[SAMPLE_WIDTH-1] && (accel_y != '0);
			pz_q <= !accel_z[SAMPLE_WIDTH-1] && (accel_z != '0);
		end
		case (cmd.op)
			toh_pkg::OP_SQX: xx_q <= sq;
			toh_pkg::OP_SQY: yy_q <= sq;
			toh_pkg::OP_SQZ: zz_q <= sq;
			toh_pkg::OP_SUM: sxy_q <= xx_q + yy_q;
			toh_pkg::OP_MULZ: prod_q <= PW'(cz) * PW'(sum3);
			toh_pkg::OP_MULX: begin
				zwin_q <= zz_sh > prod_q;
				prod_q <= PW'(cx) * PW'(sxy_q);
			end
			default: ;
		endcase
	end

	assign orientation = cur_q;

endmodule

`default_nettype wire

// ----- design/tilt_orientation_hysteresis.sv -----
`default_nettype none

// Six-way orientation detector for signed three-axis accelerometer samples.
// Each transfer on the input channel yields exactly one orientation code
// (0 none, 1 Z+, 2 Z-, 3 X+, 4 X-, 5 Y+, 6 Y-); a clear item resets the state
// to none. Angle limits come from three Q0.8 cos-squared registers (index 0
// tight, 1 base, 2 loose) chosen by the previous orientation, which gives the
// hysteresis; write them only while the block is idle. A sample passes through
// one squarer that handles the three axes in turn, one sum step, the Z and X
// limit products formed one per cycle, and a decide step that waits for a free
// result slot; a clear item goes straight to decide. The next input is accepted
// while a result waits in the output register, and the result is held until its transfer.
module tilt_orientation_hysteresis #(
	parameter int SAMPLE_WIDTH = toh_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              kind,
	input  wire logic signed [SAMPLE_WIDTH-1:0]    accel_x,
	input  wire logic signed [SAMPLE_WIDTH-1:0]    accel_y,
	input  wire logic signed [SAMPLE_WIDTH-1:0]    accel_z,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [toh_pkg::ORI_W-1:0]              orientation,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [toh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [toh_pkg::COEF_W-1:0]        cfg_data
);

	toh_pkg::dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	toh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	toh_datapath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.orientation (orientation)
	);

	// Block is busy in the cycle after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on consecutive cycles");

	// A clear item with an empty result slot reports none once it has passed the decide state
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind && !out_valid
		|=> ##1 (out_valid && orientation == toh_pkg::ORI_NONE))
		else $error("clear item did not report none");

	// A new result only appears while an item is in work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without an item in work");

endmodule

`default_nettype wire
